### src/format_specifier_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the format specifier parser
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPECIFIER_PARSER_ASSERT_SVH
`define FORMAT_SPECIFIER_PARSER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, codes and character classes for the format specifier parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FLAGS = 3'd1,
        PH_WIDTH = 3'd2,
        PH_DOT   = 3'd3,
        PH_PREC  = 3'd4,
        PH_LEN   = 3'd5
    } t_phase;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_FLAG_CLASH = 4'd1;
    localparam logic [3:0] ST_SIGN_CONV  = 4'd2;
    localparam logic [3:0] ST_ALT_BAD    = 4'd3;
    localparam logic [3:0] ST_LEN_STR    = 4'd4;
    localparam logic [3:0] ST_PREC_CHAR  = 4'd5;
    localparam logic [3:0] ST_ZERO_STR   = 4'd6;
    localparam logic [3:0] ST_NEG_PREC   = 4'd7;
    localparam logic [3:0] ST_DOUBLE_LEN = 4'd8;
    localparam logic [3:0] ST_BAD_CONV   = 4'd9;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ZERO = 2'd1;
    localparam logic [1:0] PAD_LEFT = 2'd2;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_HH   = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_H    = 2'd1;
    localparam logic [1:0] PEND_L    = 2'd2;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_J     = 8'h6a;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_UC_C  = 8'h43;

    localparam logic [15:0] SAT_MAX = 16'hffff;

    typedef struct packed {
        logic        alt_seen;
        logic [1:0]  pad_state;
        logic [1:0]  sign_state;
        logic [15:0] width_acc;
        logic        prec_seen;
        logic [15:0] prec_acc;
        logic [2:0]  length_state;
        logic [1:0]  pending_letter;
    } t_spec;

    typedef struct packed {
        logic [3:0]  status;
        logic        alt_form;
        logic [1:0]  pad_mode;
        logic [1:0]  sign_mode;
        logic [15:0] field_width;
        logic        has_precision;
        logic [15:0] precision_value;
        logic [2:0]  length_code;
        logic [7:0]  converter;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_step_out;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc * 10 + digit, saturating at 16 bits
    function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'h0000, c[3:0]};
        return (sum > {4'h0, SAT_MAX}) ? SAT_MAX : sum[15:0];
    endfunction

    function automatic logic is_signed_conv(input logic [7:0] c);
        return c inside {8'h44, 8'h49, 8'h64, 8'h69, 8'h25};
    endfunction

    function automatic logic is_alt_conv(input logic [7:0] c);
        return c inside {8'h78, 8'h58, 8'h6f, 8'h4f};
    endfunction

    function automatic logic is_str_conv(input logic [7:0] c);
        return c inside {8'h70, 8'h73, 8'h53, 8'h63, 8'h43};
    endfunction

    function automatic logic is_valid_conv(input logic [7:0] c);
        return c inside {8'h73, 8'h70, 8'h64, 8'h69, 8'h6f, 8'h75, 8'h78, 8'h63,
                         8'h43, 8'h53, 8'h44, 8'h4f, 8'h55, 8'h58, 8'h25};
    endfunction

    function automatic logic is_flag(input logic [7:0] c);
        return c inside {CH_HASH, CH_PLUS, CH_MINUS, CH_SPACE, CH_ZERO};
    endfunction

    function automatic logic is_len_char(input logic [7:0] c);
        return c inside {CH_H, CH_J, CH_Z, CH_L};
    endfunction

endpackage

`default_nettype wire

### src/fsp_if.sv
// ----------------------------------------------------------------------------
// fsp_in_if / fsp_out_if
// Valid/ready channels for character beats in and parsed specifiers out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface fsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        alt_form;
    logic [1:0]  pad_mode;
    logic [1:0]  sign_mode;
    logic [15:0] field_width;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [2:0]  length_code;
    logic [7:0]  converter;

    modport source (
        output valid, input ready,
        output status, output alt_form, output pad_mode, output sign_mode,
        output field_width, output has_precision, output precision_value,
        output length_code, output converter
    );
    modport sink (
        input valid, output ready,
        input status, input alt_form, input pad_mode, input sign_mode,
        input field_width, input has_precision, input precision_value,
        input length_code, input converter
    );
endinterface

`default_nettype wire

### src/fsp_step.sv
// ----------------------------------------------------------------------------
// fsp_step
// Next-state and result logic for one character beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_step (
    input  var fsp_pkg::t_phase    i_phase,
    input  var fsp_pkg::t_spec     i_spec,
    input  wire logic [7:0]        i_ch,
    output var fsp_pkg::t_phase    o_phase,
    output var fsp_pkg::t_spec     o_spec,
    output var fsp_pkg::t_step_out o_step
);

    fsp_pkg::t_spec es;
    logic           emit;
    logic [3:0]     st;
    logic [7:0]     conv;

    always_comb begin
        fsp_pkg::t_phase nph;
        fsp_pkg::t_spec  ns;
        logic            do_len;
        logic            done;
        logic            strish;

        nph    = i_phase;
        ns     = i_spec;
        emit   = 1'b0;
        do_len = 1'b0;
        done   = 1'b0;
        st     = fsp_pkg::ST_OK;
        conv   = 8'h00;
        strish = fsp_pkg::is_str_conv(i_ch);

        unique case (i_phase)
            fsp_pkg::PH_IDLE: begin
                if (i_ch == fsp_pkg::CH_PCT) begin
                    ns  = '0;
                    nph = fsp_pkg::PH_FLAGS;
                end
            end
            fsp_pkg::PH_FLAGS: begin
                if (fsp_pkg::is_flag(i_ch)) begin
                    if ((i_ch == fsp_pkg::CH_ZERO  && i_spec.pad_state  == fsp_pkg::PAD_LEFT)  ||
                        (i_ch == fsp_pkg::CH_MINUS && i_spec.pad_state  == fsp_pkg::PAD_ZERO)  ||
                        (i_ch == fsp_pkg::CH_PLUS  && i_spec.sign_state == fsp_pkg::SIGN_SPACE) ||
                        (i_ch == fsp_pkg::CH_SPACE && i_spec.sign_state == fsp_pkg::SIGN_PLUS)) begin
                        emit = 1'b1;
                        st   = fsp_pkg::ST_FLAG_CLASH;
                    end else begin
                        case (i_ch)
                            fsp_pkg::CH_HASH:  ns.alt_seen   = 1'b1;
                            fsp_pkg::CH_ZERO:  ns.pad_state  = fsp_pkg::PAD_ZERO;
                            fsp_pkg::CH_MINUS: ns.pad_state  = fsp_pkg::PAD_LEFT;
                            fsp_pkg::CH_PLUS:  ns.sign_state = fsp_pkg::SIGN_PLUS;
                            default:           ns.sign_state = fsp_pkg::SIGN_SPACE;
                        endcase
                    end
                end else if (i_ch >= fsp_pkg::CH_ONE && i_ch <= fsp_pkg::CH_NINE) begin
                    ns.width_acc = fsp_pkg::acc_digit(16'h0000, i_ch);
                    nph          = fsp_pkg::PH_WIDTH;
                end else if (i_ch == fsp_pkg::CH_DOT) begin
                    ns.prec_seen = 1'b1;
                    ns.prec_acc  = 16'h0000;
                    nph          = fsp_pkg::PH_DOT;
                end else begin
                    do_len = 1'b1;
                end
            end
            fsp_pkg::PH_WIDTH: begin
                if (fsp_pkg::is_digit(i_ch)) begin
                    ns.width_acc = fsp_pkg::acc_digit(i_spec.width_acc, i_ch);
                end else if (i_ch == fsp_pkg::CH_DOT) begin
                    ns.prec_seen = 1'b1;
                    ns.prec_acc  = 16'h0000;
                    nph          = fsp_pkg::PH_DOT;
                end else begin
                    do_len = 1'b1;
                end
            end
            fsp_pkg::PH_DOT: begin
                if (i_ch == fsp_pkg::CH_MINUS) begin
                    emit = 1'b1;
                    st   = fsp_pkg::ST_NEG_PREC;
                end else if (fsp_pkg::is_digit(i_ch)) begin
                    ns.prec_acc = fsp_pkg::acc_digit(16'h0000, i_ch);
                    nph         = fsp_pkg::PH_PREC;
                end else begin
                    do_len = 1'b1;
                end
            end
            fsp_pkg::PH_PREC: begin
                if (fsp_pkg::is_digit(i_ch)) begin
                    ns.prec_acc = fsp_pkg::acc_digit(i_spec.prec_acc, i_ch);
                end else begin
                    do_len = 1'b1;
                end
            end
            fsp_pkg::PH_LEN: begin
                do_len = 1'b1;
            end
            default: begin
                nph = fsp_pkg::PH_IDLE;
            end
        endcase

        if (do_len) begin
            nph = fsp_pkg::PH_LEN;
            // pending h or l: a doubled letter completes it, anything else commits it
            if (ns.pending_letter != fsp_pkg::PEND_NONE) begin
                if (ns.pending_letter == fsp_pkg::PEND_H) begin
                    if (i_ch == fsp_pkg::CH_H) begin
                        ns.length_state = fsp_pkg::LEN_HH;
                        done            = 1'b1;
                    end else begin
                        ns.length_state = fsp_pkg::LEN_H;
                    end
                end else begin
                    if (i_ch == fsp_pkg::CH_L) begin
                        ns.length_state = fsp_pkg::LEN_LL;
                        done            = 1'b1;
                    end else begin
                        ns.length_state = fsp_pkg::LEN_L;
                    end
                end
                ns.pending_letter = fsp_pkg::PEND_NONE;
            end
            if (!done) begin
                if (fsp_pkg::is_len_char(i_ch)) begin
                    if (ns.length_state != fsp_pkg::LEN_NONE) begin
                        emit = 1'b1;
                        st   = fsp_pkg::ST_DOUBLE_LEN;
                    end else begin
                        case (i_ch)
                            fsp_pkg::CH_H: ns.pending_letter = fsp_pkg::PEND_H;
                            fsp_pkg::CH_L: ns.pending_letter = fsp_pkg::PEND_L;
                            fsp_pkg::CH_J: ns.length_state   = fsp_pkg::LEN_J;
                            default:       ns.length_state   = fsp_pkg::LEN_Z;
                        endcase
                    end
                end else begin
                    emit = 1'b1;
                    conv = i_ch;
                    if (ns.sign_state != fsp_pkg::SIGN_NONE && !fsp_pkg::is_signed_conv(i_ch))
                        st = fsp_pkg::ST_SIGN_CONV;
                    else if (ns.alt_seen && !fsp_pkg::is_alt_conv(i_ch))
                        st = fsp_pkg::ST_ALT_BAD;
                    else if ((ns.length_state == fsp_pkg::LEN_H ||
                              ns.length_state == fsp_pkg::LEN_HH ||
                              ns.length_state == fsp_pkg::LEN_J ||
                              ns.length_state == fsp_pkg::LEN_Z) && strish)
                        st = fsp_pkg::ST_LEN_STR;
                    else if ((i_ch == fsp_pkg::CH_LC_C || i_ch == fsp_pkg::CH_UC_C) &&
                             ns.prec_seen)
                        st = fsp_pkg::ST_PREC_CHAR;
                    else if (ns.pad_state == fsp_pkg::PAD_ZERO && strish)
                        st = fsp_pkg::ST_ZERO_STR;
                    else if (!fsp_pkg::is_valid_conv(i_ch))
                        st = fsp_pkg::ST_BAD_CONV;
                    else
                        st = fsp_pkg::ST_OK;
                end
            end
        end

        es = ns;
        if (emit) begin
            ns  = '0;
            nph = fsp_pkg::PH_IDLE;
        end

        o_phase = nph;
        o_spec  = ns;
    end

    always_comb begin
        o_step.emit                   = emit;
        o_step.result.status          = st;
        o_step.result.alt_form        = es.alt_seen;
        o_step.result.pad_mode        = es.pad_state;
        o_step.result.sign_mode       = es.sign_state;
        o_step.result.field_width     = es.width_acc;
        o_step.result.has_precision   = es.prec_seen;
        o_step.result.precision_value = es.prec_acc;
        o_step.result.length_code     = es.length_state;
        o_step.result.converter       = conv;
    end

endmodule

`default_nettype wire

### src/format_specifier_parser.sv
// The result is valid on o_out in the cycle after the beat that ends the specifier.
// Throughput: one character beat per cycle; stalls while an untaken result waits.
// The beat rate is set by the single state/result register stage around fsp_step.
// Reset (i_rst_n low, synchronous): parser idle, fields cleared, output empty.
// ----------------------------------------------------------------------------
// format_specifier_parser
// Streams format-string bytes and emits one parsed specifier per '%' sequence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "format_specifier_parser_assert.svh"

module format_specifier_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsp_in_if.sink     i_in,
    fsp_out_if.source  o_out
);

    fsp_pkg::t_phase    r_phase;
    fsp_pkg::t_phase    n_phase;
    fsp_pkg::t_spec     r_spec;
    fsp_pkg::t_spec     n_spec;
    fsp_pkg::t_result   r_out;
    logic               r_out_valid;
    fsp_pkg::t_step_out step;
    logic               in_beat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;

    fsp_step u_step (
        .i_phase (r_phase),
        .i_spec  (r_spec),
        .i_ch    (i_in.ch),
        .o_phase (n_phase),
        .o_spec  (n_spec),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fsp_pkg::PH_IDLE;
            r_spec      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_phase <= n_phase;
                r_spec  <= n_spec;
            end
            if (in_beat && step.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && step.emit) begin
            r_out <= step.result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.alt_form        = r_out.alt_form;
    assign o_out.pad_mode        = r_out.pad_mode;
    assign o_out.sign_mode       = r_out.sign_mode;
    assign o_out.field_width     = r_out.field_width;
    assign o_out.has_precision   = r_out.has_precision;
    assign o_out.precision_value = r_out.precision_value;
    assign o_out.length_code     = r_out.length_code;
    assign o_out.converter       = r_out.converter;

    `FSP_ASSERT_SAME(a_idle_clear, r_phase == fsp_pkg::PH_IDLE, r_spec == '0,
        "fields not clear in idle")
    `FSP_ASSERT_SAME(a_pend_in_len, r_spec.pending_letter != fsp_pkg::PEND_NONE,
        r_phase == fsp_pkg::PH_LEN, "pending letter outside length phase")
    `FSP_ASSERT_SAME(a_early_conv,
        r_out_valid && (r_out.status == fsp_pkg::ST_FLAG_CLASH ||
                        r_out.status == fsp_pkg::ST_NEG_PREC ||
                        r_out.status == fsp_pkg::ST_DOUBLE_LEN),
        r_out.converter == 8'h00, "early error carries converter")
    `FSP_ASSERT_NEXT(a_emit_shows, in_beat && step.emit,
        o_out.valid && $past(r_phase) != fsp_pkg::PH_IDLE, "emitted result not presented")

endmodule

`default_nettype wire
